// ===== hw/rtl/iee_pkg.sv =====
// shared types and character codes for the infix expression evaluator
package iee_pkg;

  localparam int unsigned SYMBOL_W    = 8;
  localparam int unsigned OPND_W      = 9;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'd45;
  localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'd42;
  localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'd47;

  typedef enum logic [2:0] {
    CMD_OPERAND = 3'd0,
    CMD_MUL     = 3'd1,
    CMD_DIV     = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_SUB     = 3'd4,
    CMD_FINISH  = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [SYMBOL_W-1:0]   symbol;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

// ===== hw/rtl/iee_intf.sv =====
// request channels for symbols in and results out
interface iee_sym_if import iee_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface iee_res_if import iee_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      div_by_zero;

  modport source (output valid, output value, output div_by_zero, input ready);
  modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

// ===== hw/rtl/iee_front.sv =====
// front end: accepts symbols and classifies them into commands
module iee_front import iee_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sym_valid_i,
  input  logic [SYMBOL_W-1:0] sym_symbol_i,
  output logic                sym_ready_o,
  input  logic                full_i,
  output cmd_req_t            push_o
);

  logic expect_op_q, expect_op_d;
  logic accept;

  assign sym_ready_o = !full_i;
  assign accept      = sym_valid_i && !full_i;

  always_comb begin
    push_o.valid      = accept;
    push_o.cmd.symbol = sym_symbol_i;
    expect_op_d       = expect_op_q;
    if (!expect_op_q) begin
      push_o.cmd.kind = CMD_OPERAND;
    end else if (sym_symbol_i == CH_STAR) begin
      push_o.cmd.kind = CMD_MUL;
    end else if (sym_symbol_i == CH_SLASH) begin
      push_o.cmd.kind = CMD_DIV;
    end else if (sym_symbol_i == CH_PLUS) begin
      push_o.cmd.kind = CMD_ADD;
    end else if (sym_symbol_i == CH_MINUS) begin
      push_o.cmd.kind = CMD_SUB;
    end else begin
      push_o.cmd.kind = CMD_FINISH;
    end
    if (accept) begin
      expect_op_d = !expect_op_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_op_q <= 1'b0;
    end else begin
      expect_op_q <= expect_op_d;
    end
  end

endmodule

// ===== hw/rtl/iee_queue.sv =====
// short command queue between front and back
module iee_queue import iee_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_req_t push_i,
  output logic     full_o,
  output cmd_req_t head_o,
  input  logic     pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/iee_div.sv =====
// radix-2 restoring unsigned divider, one quotient bit per cycle
module iee_div #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_WIDTH-1:0] dividend_i,
  input  logic [WORD_WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WORD_WIDTH-1:0] rem_q, rem_d;
  logic [WORD_WIDTH-1:0] quo_q, quo_d;
  logic [WORD_WIDTH-1:0] dsr_q, dsr_d;
  logic [WORD_WIDTH+1:0] trial;

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign trial      = {1'b0, rem_q, quo_q[WORD_WIDTH-1]} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WORD_WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[WORD_WIDTH+1]) begin
        rem_d = trial[WORD_WIDTH-1:0];
        quo_d = {quo_q[WORD_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WORD_WIDTH-2:0], quo_q[WORD_WIDTH-1]};
        quo_d = {quo_q[WORD_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

endmodule

// ===== hw/rtl/iee_back.sv =====
// back end: executes commands, keeps sum and term, holds the result register
module iee_back import iee_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_req_t                  head_i,
  output logic                      pop_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic signed [VALUE_W-1:0] res_value_o,
  output logic                      res_div_by_zero_o
);

  localparam int unsigned EXT_W = (WORD_WIDTH > VALUE_W) ? WORD_WIDTH : VALUE_W;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic [WORD_WIDTH-1:0]     sum_q, sum_d;
  logic [WORD_WIDTH-1:0]     term_q, term_d;
  logic                      sub_q, sub_d;
  logic                      pdiv_q, pdiv_d;
  logic                      tho_q, tho_d;
  logic                      err_q, err_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic                      out_err_q, out_err_d;

  logic [OPND_W-1:0]               opnd;
  logic [WORD_WIDTH-1:0]           opnd_word;
  logic signed [WORD_WIDTH+OPND_W:0] prod;
  logic [WORD_WIDTH-1:0]           fold;
  logic signed [EXT_W-1:0]         fold_ext;
  logic                            div_start;
  logic                            div_done;
  logic [WORD_WIDTH-1:0]           div_quot;

  assign opnd      = {1'b0, head_i.cmd.symbol} - {1'b0, CH_ZERO};
  assign opnd_word = WORD_WIDTH'($signed(opnd));
  assign prod      = $signed({1'b0, term_q}) * $signed(opnd);
  assign fold      = sub_q ? (sum_q - term_q) : (sum_q + term_q);
  assign fold_ext  = EXT_W'($signed(fold));

  assign res_valid_o       = out_valid_q;
  assign res_value_o       = out_value_q;
  assign res_div_by_zero_o = out_err_q;

  always_comb begin
    pop_o = head_i.valid && (state_q == ST_RUN)
            && !((head_i.cmd.kind == CMD_FINISH) && out_valid_q);
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    term_d      = term_q;
    sub_d       = sub_q;
    pdiv_d      = pdiv_q;
    tho_d       = tho_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    div_start   = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (pop_o) begin
          unique case (head_i.cmd.kind)
            CMD_OPERAND: begin
              tho_d = 1'b0;
              if (!tho_q) begin
                term_d = opnd_word;
              end else if (!pdiv_q) begin
                term_d = prod[WORD_WIDTH-1:0];
              end else if (opnd_word == '0) begin
                term_d = '1;
                err_d  = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            CMD_MUL, CMD_DIV: begin
              pdiv_d = (head_i.cmd.kind == CMD_DIV);
              tho_d  = 1'b1;
            end
            CMD_ADD, CMD_SUB: begin
              sum_d  = fold;
              sub_d  = (head_i.cmd.kind == CMD_SUB);
              term_d = '0;
              tho_d  = 1'b0;
            end
            CMD_FINISH: begin
              out_valid_d = 1'b1;
              out_value_d = fold_ext[VALUE_W-1:0];
              out_err_d   = err_q;
              sum_d       = '0;
              term_d      = '0;
              sub_d       = 1'b0;
              pdiv_d      = 1'b0;
              tho_d       = 1'b0;
              err_d       = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          term_d  = div_quot;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  iee_div #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (term_q),
    .divisor_i  (opnd_word),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      sum_q       <= '0;
      term_q      <= '0;
      sub_q       <= 1'b0;
      pdiv_q      <= 1'b0;
      tho_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      sub_q       <= sub_d;
      pdiv_q      <= pdiv_d;
      tho_q       <= tho_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

endmodule

// ===== hw/rtl/infix_expression_evaluator.sv =====
// top level of the streaming infix expression evaluator
// One character is taken per request; the front end classifies it and queues a
// command, and the back end applies it to the running sum and term, so the
// input side takes one character per cycle while the two-entry queue has room.
// Most commands retire as they are popped. An operand that follows a division
// holds the back end in its divide state while the radix-2 divider produces
// one quotient bit per cycle; that divider sets the worst-case rate. A zero
// divisor skips the divider, gives an all-ones term and sets div_by_zero in
// the result. A non-operator at an operator position ends the expression and
// places one result in the output register, which may wait for its taker
// while the next expression is already being accepted.
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iee_sym_if.sink    sym_i,
  iee_res_if.source  res_o
);

  cmd_req_t push;
  cmd_req_t head;
  logic     full;
  logic     pop;

  iee_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_valid_i  (sym_i.valid),
    .sym_symbol_i (sym_i.symbol),
    .sym_ready_o  (sym_i.ready),
    .full_i       (full),
    .push_o       (push)
  );

  iee_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  iee_back #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .pop_o             (pop),
    .res_valid_o       (res_o.valid),
    .res_ready_i       (res_o.ready),
    .res_value_o       (res_o.value),
    .res_div_by_zero_o (res_o.div_by_zero)
  );

endmodule

// ===== hw/rtl/iee_checker.sv =====
// port-level assertions for the infix expression evaluator and their bind
module iee_checker import iee_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      sym_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic signed [VALUE_W-1:0] res_value_i,
  input logic                      res_div_by_zero_i
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_value_i) && $stable(res_div_by_zero_i))
    else $error("result changed while stalled");

  // a new result never follows a taken one in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i |=> !res_valid_i)
    else $error("result reissued right after transfer");

  // out of reset: queue empty, no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> sym_ready_i && !res_valid_i)
    else $error("bad state after reset");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .sym_ready_i       (sym_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_value_i       (res_o.value),
  .res_div_by_zero_i (res_o.div_by_zero)
);

// ===== bench/infix_expression_evaluator_test.sv =====
// testbench for infix_expression_evaluator: character stream against an expression predictor
`timescale 1ns / 100ps

module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               div_by_zero;
  } expr_value_t;

  logic clk = 1'b0;
  logic rst_n;

  iee_sym_if sym_if ();
  iee_res_if res_if ();

  infix_expression_evaluator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .sym_i (sym_if),
    .res_o (res_if)
  );

  always #1 clk = ~clk;

  // expression state as the block should hold it
  logic [VALUE_W-1:0] acc_sum;
  logic               sub_pending;
  logic [VALUE_W-1:0] acc_term;
  logic               div_pending;
  logic               term_waiting;
  logic               at_operator;
  logic               zero_divisor_seen;

  expr_value_t pending_values[$];

  int unsigned fail_count   = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold_len = 0;
  bit          hold_active  = 1'b0;
  bit          idle_enabled = 1'b1;

  task automatic clear_evaluator();
    acc_sum           = '0;
    sub_pending       = 1'b0;
    acc_term          = '0;
    div_pending       = 1'b0;
    term_waiting      = 1'b0;
    at_operator       = 1'b0;
    zero_divisor_seen = 1'b0;
  endtask

  task automatic evaluate_symbol(input logic [SYMBOL_W-1:0] s);
    logic [VALUE_W-1:0] operand;
    expr_value_t        done;
    operand = VALUE_W'(s) - VALUE_W'(CH_ZERO);
    if (!at_operator) begin
      if (term_waiting) begin
        if (div_pending) begin
          if (operand == '0) begin
            acc_term          = '1;
            zero_divisor_seen = 1'b1;
          end else begin
            acc_term = acc_term / operand;
          end
        end else begin
          acc_term = acc_term * operand;
        end
      end else begin
        acc_term = operand;
      end
      term_waiting = 1'b0;
      at_operator  = 1'b1;
    end else if (s == CH_STAR || s == CH_SLASH) begin
      div_pending  = (s == CH_SLASH);
      term_waiting = 1'b1;
      at_operator  = 1'b0;
    end else if (s == CH_PLUS || s == CH_MINUS) begin
      acc_sum      = sub_pending ? acc_sum - acc_term : acc_sum + acc_term;
      sub_pending  = (s == CH_MINUS);
      acc_term     = '0;
      term_waiting = 1'b0;
      at_operator  = 1'b0;
    end else begin
      done.value       = sub_pending ? acc_sum - acc_term : acc_sum + acc_term;
      done.div_by_zero = zero_divisor_seen;
      pending_values.push_back(done);
      clear_evaluator();
    end
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_symbol(input logic [SYMBOL_W-1:0] s);
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      sym_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    sym_if.valid  <= 1'b1;
    sym_if.symbol <= s;
    do @(posedge clk); while (!sym_if.ready);
    evaluate_symbol(s);
    items_sent++;
  endtask

  task automatic send_string(input string txt);
    for (int k = 0; k < txt.len(); k++) send_symbol(txt[k]);
  endtask

  function automatic logic [SYMBOL_W-1:0] pick_operand();
    if ($urandom_range(0, 15) == 0) return SYMBOL_W'($urandom_range(0, 255));
    return CH_ZERO + SYMBOL_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_terminator();
    logic [SYMBOL_W-1:0] s;
    do s = SYMBOL_W'($urandom_range(0, 255));
    while (s inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
    return s;
  endfunction

  task automatic send_expression(input int unsigned max_operands);
    int unsigned n_operands;
    n_operands = $urandom_range(1, max_operands);
    for (int unsigned k = 0; k < n_operands; k++) begin
      if (k != 0) send_symbol(pick_operator());
      send_symbol(pick_operand());
    end
    send_symbol(pick_terminator());
  endtask

  // arbitrary bytes, operators favored, so positions and terminators fall anywhere
  task automatic send_noise(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) send_symbol(pick_operator());
      else send_symbol(SYMBOL_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    send_string("7+8*9-6/4=");
    send_string("5/0");
    send_symbol(8'hFF);
    send_symbol(8'h00);
    send_string("/7*");
    send_symbol(8'hFF);
    send_symbol(8'h00);
    send_string("3-9 ");
  endtask

  task automatic test_random_expressions();
    while (items_sent < 620) begin
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 12));
      else send_expression(8);
    end
  endtask

  // result side held off while short expressions keep coming
  task automatic test_output_stall();
    sym_if.valid <= 1'b0;
    ready_hold_len = HOLD_CYCLES;
    wait (hold_active);
    @(posedge clk);
    repeat (25) begin
      send_symbol(pick_operand());
      send_symbol(pick_terminator());
    end
  endtask

  task automatic test_pause_for_results();
    repeat (4) begin
      repeat (3) send_expression(4);
      sym_if.valid <= 1'b0;
      wait (pending_values.size() == 0);
      @(posedge clk);
    end
  endtask

  task automatic test_no_idling();
    int unsigned target;
    idle_enabled = 1'b0;
    target = items_sent + 150;
    while (items_sent < target) send_expression(6);
  endtask

  initial begin
    rst_n = 1'b0;
    sym_if.valid  <= 1'b0;
    sym_if.symbol <= '0;
    clear_evaluator();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_expressions();
    test_output_stall();
    test_pause_for_results();
    test_no_idling();
    sym_if.valid <= 1'b0;
    wait (pending_values.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stretch;
    res_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (ready_hold_len != 0) begin
        stretch        = ready_hold_len;
        ready_hold_len = 0;
        hold_active    = 1'b1;
        res_if.ready <= 1'b0;
        repeat (stretch) @(posedge clk);
        hold_active = 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_checker
    expr_value_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_values.size() == 0) begin
        report_failure($sformatf("unexpected result: value %0d div_by_zero %0b",
                                 $signed(res_if.value), res_if.div_by_zero));
      end else begin
        want = pending_values.pop_front();
        if (res_if.value !== want.value)
          report_failure($sformatf("value: expected %0d, got %0d",
                                   $signed(want.value), $signed(res_if.value)));
        if (res_if.div_by_zero !== want.div_by_zero)
          report_failure($sformatf("div_by_zero: expected %0b, got %0b",
                                   want.div_by_zero, res_if.div_by_zero));
      end
    end
  end

  initial begin : watchdog
    wait (rst_n);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/iee_pkg.sv
hw/rtl/iee_intf.sv
hw/rtl/iee_front.sv
hw/rtl/iee_queue.sv
hw/rtl/iee_div.sv
hw/rtl/iee_back.sv
hw/rtl/infix_expression_evaluator.sv
hw/rtl/iee_checker.sv
bench/infix_expression_evaluator_test.sv
